// ===== design/bmm_pkg.sv =====
`default_nettype none

package bmm_pkg;

   localparam int DIM_W  = 4;
   localparam int SIZE_W = 5;
   localparam int VAL_W  = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== design/byte_matrix_multiply_mod256.sv =====
// Write items are accepted only while idle and leave the block idle and ready.
// A compute item of size n runs column by column: for each column reads issue
// for n elements in RUN, the last product is added in DRAIN, and EMIT loads the
// result register, waiting while it is full. Synchronous reset clears the
// sequencer and output valid and sets the size to 16; the stores are not cleared.
`default_nettype none

module byte_matrix_multiply_mod256 #(
   parameter int MAX_SIZE = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   // Request tdata: row [3:0], col [7:4], value [15:8]. tuser: op.
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [15:0]                  req_tdata,
   input  wire  [1:0]                   req_tuser,
   // Response tdata: out_col [3:0], out_value [11:4], zero [15:12].
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic                         rsp_tlast,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [bmm_pkg::SIZE_W-1:0]   csr_data
);

   import bmm_pkg::*;

   localparam int SIZE_LIMIT = (MAX_SIZE < 16) ? MAX_SIZE : 16;
   localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [SIZE_W-1:0] n_use;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  j_ff, j_in;
   logic [DIM_W-1:0]  k_ff, k_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic              rd_valid_ff;
   logic [VAL_W-1:0]  a_rd_ff, b_rd_ff;

   logic              out_valid_ff, out_valid_in;
   logic [DIM_W-1:0]  out_col_ff, out_col_in;
   logic [VAL_W-1:0]  out_val_ff, out_val_in;
   logic              out_last_ff, out_last_in;

   logic [VAL_W-1:0] mat_a_ff [DEPTH];
   logic [VAL_W-1:0] mat_b_ff [DEPTH];

   logic [DIM_W-1:0] in_row, in_col;
   logic [VAL_W-1:0] in_value;
   op_type           in_op;
   logic             req_fire, in_range, compute_go;
   logic             k_last, j_last, out_free;
   logic             issue, emit;
   logic [31:0]      wr_addr_full, a_addr_full, b_addr_full;
   logic [AW-1:0]    wr_addr, a_addr, b_addr;
   logic [2*VAL_W-1:0] product;

   assign in_row   = req_tdata[3:0];
   assign in_col   = req_tdata[7:4];
   assign in_value = req_tdata[15:8];
   assign in_op    = op_type'(req_tuser);

   assign req_fire = req_tvalid && req_tready;
   assign in_range = (int'(in_row) < MAX_SIZE) && (int'(in_col) < MAX_SIZE);

   always_comb begin
      if (size_ff == '0) begin
         n_use = SIZE_W'(1);
      end else if (int'(size_ff) > SIZE_LIMIT) begin
         n_use = SIZE_W'(SIZE_LIMIT);
      end else begin
         n_use = size_ff;
      end
   end

   assign compute_go = req_fire && (in_op == OP_COMPUTE) && ({1'b0, in_row} < n_use);
   assign k_last     = ({1'b0, k_ff} + SIZE_W'(1)) == n_ff;
   assign j_last     = ({1'b0, j_ff} + SIZE_W'(1)) == n_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (compute_go) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = j_last ? ST_IDLE : ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_RUN: begin
            issue = 1'b1;
         end
         ST_DRAIN: begin
            issue = 1'b0;
         end
         ST_EMIT: begin
            emit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign wr_addr_full = 32'(in_row) * 32'(MAX_SIZE) + 32'(in_col);
   assign a_addr_full  = 32'(row_ff) * 32'(MAX_SIZE) + 32'(k_ff);
   assign b_addr_full  = 32'(k_ff) * 32'(MAX_SIZE) + 32'(j_ff);
   assign wr_addr      = wr_addr_full[AW-1:0];
   assign a_addr       = a_addr_full[AW-1:0];
   assign b_addr       = b_addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (req_fire && in_range && (in_op == OP_WRITE_A)) begin
         mat_a_ff[wr_addr] <= in_value;
      end
      if (issue) begin
         a_rd_ff <= mat_a_ff[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_range && (in_op == OP_WRITE_B)) begin
         mat_b_ff[wr_addr] <= in_value;
      end
      if (issue) begin
         b_rd_ff <= mat_b_ff[b_addr];
      end
   end

   assign product = a_rd_ff * b_rd_ff;

   always_comb begin
      size_in     = size_ff;
      n_in        = n_ff;
      row_in      = row_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      out_valid_in = out_valid_ff;
      out_col_in  = out_col_ff;
      out_val_in  = out_val_ff;
      out_last_in = out_last_ff;

      if (csr_valid && csr_ready) begin
         size_in = csr_data;
      end

      if (rd_valid_ff) begin
         acc_in = acc_ff + product[VAL_W-1:0];
      end

      if (compute_go) begin
         n_in   = n_use;
         row_in = in_row;
         j_in   = '0;
         k_in   = '0;
         acc_in = '0;
      end

      if (issue) begin
         k_in = k_last ? '0 : k_ff + DIM_W'(1);
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_col_in   = j_ff;
         out_val_in   = acc_ff;
         out_last_in  = j_last;
         j_in         = j_ff + DIM_W'(1);
         acc_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rd_valid_ff  <= issue;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      row_ff      <= row_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_val_ff, out_col_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
